// File: design/apcm_pkg.sv
// ----------------------------------------------------------------------------
// apcm_pkg: shared types and constants of the palette color mapper
// Match kind codes, fixed field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
package apcm_pkg;

  localparam int unsigned CHAN_W  = 8;   // one color component
  localparam int unsigned INDEX_W = 8;   // color_index port
  localparam int unsigned KIND_W  = 2;   // match_kind port
  localparam int unsigned DIST_W  = 18;  // squared_distance port
  localparam int unsigned SIZE_W  = 9;   // palette_size register
  localparam int unsigned SQ_W    = 2 * CHAN_W;

  localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 9'd256;

  localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture pixel, rewind address, clear best candidate
    logic scan;    // issue one palette read and advance the address
    logic finish;  // resolve the request, append on a miss if there is room, strobe result
  } apcm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic used_zero;  // palette is empty
    logic scan_last;  // current address is the last entry in use
    logic pipe_busy;  // a read or a distance is still in flight
  } apcm_status_t;

endpackage

// File: design/apcm_ctrl.sv
// ----------------------------------------------------------------------------
// apcm_ctrl: sequencer of the palette color mapper
// Walks one request through load, scan, pipeline drain and finish (empty palette: load, finish).
// ----------------------------------------------------------------------------
module apcm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  apcm_pkg::apcm_status_t status,
  output apcm_pkg::apcm_cmd_t    cmd
);
  import apcm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && start;
    cmd.scan   = (state == ST_SCAN);
    cmd.finish = (state == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= status.used_zero ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/apcm_datapath.sv
// ----------------------------------------------------------------------------
// apcm_datapath: palette store, distance pipeline and result registers
// One entry read per cycle; squares registered, then sum and running minimum.
// ----------------------------------------------------------------------------
module apcm_datapath #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  apcm_pkg::apcm_cmd_t                  cmd,
  output apcm_pkg::apcm_status_t               status,
  input  logic                                cfg_write,
  input  logic [apcm_pkg::SIZE_W-1:0]          cfg_data,
  input  logic [apcm_pkg::CHAN_W-1:0]          red,
  input  logic [apcm_pkg::CHAN_W-1:0]          green,
  input  logic [apcm_pkg::CHAN_W-1:0]          blue,
  output logic                                done,
  output logic [apcm_pkg::INDEX_W-1:0]         color_index,
  output logic [apcm_pkg::KIND_W-1:0]          match_kind,
  output logic [apcm_pkg::DIST_W-1:0]          squared_distance
);
  import apcm_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ENTRIES);

  // configuration and occupancy
  logic [SIZE_W-1:0] palette_size;
  logic [CNT_W-1:0]  entries_used;
  logic [SIZE_W-1:0] limit;
  logic              room;

  // captured pixel
  logic [CHAN_W-1:0] pix_r, pix_g, pix_b;

  // palette store
  logic [3*CHAN_W-1:0] mem [MAX_ENTRIES];
  logic [3*CHAN_W-1:0] rd_data;
  logic [IDX_W-1:0]    addr;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;

  // square stage
  logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic              sq_valid;
  logic [IDX_W-1:0]  sq_idx;
  logic [DIST_W-1:0] sum;

  // running minimum
  logic              best_valid;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;

  assign limit = (palette_size > MAX_SIZE) ? MAX_SIZE : palette_size;
  assign room  = (SIZE_W'(entries_used) < limit);

  assign status.used_zero = (entries_used == '0);
  assign status.scan_last = (CNT_W'(addr) + CNT_W'(1)) == entries_used;
  assign status.pipe_busy = rd_valid || sq_valid;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign diff_r = abs_diff(pix_r, rd_data[3*CHAN_W-1:2*CHAN_W]);
  assign diff_g = abs_diff(pix_g, rd_data[2*CHAN_W-1:CHAN_W]);
  assign diff_b = abs_diff(pix_b, rd_data[CHAN_W-1:0]);
  assign sum    = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= PALETTE_SIZE_RESET;
    end else if (cfg_write) begin
      palette_size <= cfg_data;
    end
  end

  // memory: one write on append, one registered read per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.finish && !(best_valid && best_dist == '0) && room) begin
      mem[entries_used[IDX_W-1:0]] <= {pix_r, pix_g, pix_b};
    end
    if (cmd.scan) begin
      rd_data <= mem[addr];
    end
  end

  // pixel capture, address, pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= red;
      pix_g <= green;
      pix_b <= blue;
    end
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.scan) begin
      addr <= addr + IDX_W'(1);
    end
    rd_idx <= addr;
    sq_idx <= rd_idx;
    sq_r   <= SQ_W'(diff_r) * SQ_W'(diff_r);
    sq_g   <= SQ_W'(diff_g) * SQ_W'(diff_g);
    sq_b   <= SQ_W'(diff_b) * SQ_W'(diff_b);
  end

  // control flags, best candidate, occupancy, results
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      sq_valid     <= 1'b0;
      best_valid   <= 1'b0;
      entries_used <= '0;
      done         <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      sq_valid <= rd_valid;
      done     <= cmd.finish;
      if (cmd.load) begin
        best_valid <= 1'b0;
      end else if (sq_valid && (!best_valid || sum < best_dist)) begin
        best_valid <= 1'b1;
      end
      if (cmd.finish && !(best_valid && best_dist == '0) && room) begin
        entries_used <= entries_used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_dist <= '0;
      best_idx  <= '0;
    end else if (sq_valid && (!best_valid || sum < best_dist)) begin
      best_dist <= sum;
      best_idx  <= sq_idx;
    end
    if (cmd.finish) begin
      if (best_valid && best_dist == '0) begin
        color_index      <= INDEX_W'(best_idx);
        match_kind       <= KIND_EXACT;
        squared_distance <= '0;
      end else if (room) begin
        color_index      <= INDEX_W'(entries_used);
        match_kind       <= KIND_NEW;
        squared_distance <= '0;
      end else begin
        color_index      <= INDEX_W'(best_idx);
        match_kind       <= KIND_NEAREST;
        squared_distance <= best_dist;
      end
    end
  end

endmodule

// File: design/adaptive_palette_color_mapper_unit.sv
// ----------------------------------------------------------------------------
// adaptive_palette_color_mapper_unit: RGB pixel to palette index mapper
// Exact match, append on miss while room, else nearest entry by squared RGB.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------
// request   start / busy           red, green, blue
// result    done (one-cycle)       color_index, match_kind, squared_distance
// config    cfg_valid / cfg_ready  cfg_data (palette_size)
//
// A request taken at start && !busy scans every entry in use, one memory read
// per cycle; an empty palette skips the scan. The single palette read port
// sets that read rate. A new request may be taken in the cycle done is high.
// Reset (rst, synchronous) empties the palette and sets palette_size to 256;
// the store itself is not cleared, entries are only read once written.
// The receiver cannot stall: each result is valid only while done is high.
//
module adaptive_palette_color_mapper_unit #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [apcm_pkg::CHAN_W-1:0]  red,
  input  logic [apcm_pkg::CHAN_W-1:0]  green,
  input  logic [apcm_pkg::CHAN_W-1:0]  blue,
  output logic                         done,
  output logic [apcm_pkg::INDEX_W-1:0] color_index,
  output logic [apcm_pkg::KIND_W-1:0]  match_kind,
  output logic [apcm_pkg::DIST_W-1:0]  squared_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [apcm_pkg::SIZE_W-1:0]  cfg_data
);
  import apcm_pkg::*;

  apcm_cmd_t    cmd;
  apcm_status_t status;
  logic         cfg_write;

  // palette_size may only change between requests
  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // sequencer: idle -> scan -> drain -> finish
  apcm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // store, distance pipeline (read, square, sum/compare), result registers
  apcm_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .done             (done),
    .color_index      (color_index),
    .match_kind       (match_kind),
    .squared_distance (squared_distance)
  );

`ifndef ASSERT_OFF
  // a taken request always holds the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // exact and new results carry zero distance
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (done && (match_kind == KIND_EXACT || match_kind == KIND_NEW))
      |-> (squared_distance == '0))
    else $error("nonzero distance on exact or new result");

  // the block comes out of reset idle and silent
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");
`endif

endmodule

// File: verif/apcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcm_checker: scoreboard for the adaptive palette color mapper
// Mirrors the palette on every accepted request and compares each done
// strobe field by field against the oldest predicted mapping.
// ----------------------------------------------------------------------------
module apcm_checker #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [apcm_pkg::CHAN_W-1:0]  red,
  input  logic [apcm_pkg::CHAN_W-1:0]  green,
  input  logic [apcm_pkg::CHAN_W-1:0]  blue,
  input  logic                         done,
  input  logic [apcm_pkg::INDEX_W-1:0] color_index,
  input  logic [apcm_pkg::KIND_W-1:0]  match_kind,
  input  logic [apcm_pkg::DIST_W-1:0]  squared_distance,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [apcm_pkg::SIZE_W-1:0]  cfg_data,
  output int                           error_count,
  output int                           results_outstanding
);
  import apcm_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [KIND_W-1:0]  kind;
    logic [DIST_W-1:0]  sq_dist;
  } mapping_t;

  logic [3*CHAN_W-1:0] palette [MAX_ENTRIES];
  int unsigned         entries_used;
  logic [SIZE_W-1:0]   palette_size;
  mapping_t            expected_mappings [$];

  function automatic int unsigned sq_delta(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // exact hit first, else append while room, else lowest-index nearest entry
  task automatic map_pixel(input logic [3*CHAN_W-1:0] color, output mapping_t m);
    int unsigned room;
    int unsigned d;
    bit          hit;
    bit          any;
    room = (palette_size > MAX_ENTRIES) ? MAX_ENTRIES : palette_size;
    hit  = 0;
    any  = 0;
    m    = '{index: '0, kind: KIND_NEAREST, sq_dist: '0};
    for (int unsigned i = 0; i < entries_used && !hit; i++) begin
      if (palette[i] == color) begin
        hit     = 1;
        m.index = i[INDEX_W-1:0];
        m.kind  = KIND_EXACT;
      end
    end
    if (!hit) begin
      if (entries_used < room) begin
        palette[entries_used] = color;
        m.index = entries_used[INDEX_W-1:0];
        m.kind  = KIND_NEW;
        entries_used++;
      end else begin
        for (int unsigned i = 0; i < entries_used; i++) begin
          d = sq_delta(color[23:16], palette[i][23:16]) +
              sq_delta(color[15:8], palette[i][15:8]) +
              sq_delta(color[7:0], palette[i][7:0]);
          if (!any || d < m.sq_dist) begin
            any       = 1;
            m.sq_dist = d[DIST_W-1:0];
            m.index   = i[INDEX_W-1:0];
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    mapping_t want;
    mapping_t fresh;
    if (rst) begin
      entries_used = 0;
      palette_size = PALETTE_SIZE_RESET;
      expected_mappings.delete();
      error_count  = 0;
    end else begin
      // result first: a request taken on this edge cannot complete on it
      if (done) begin
        if (expected_mappings.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got index %0d kind %0d dist %0d",
                   $time, color_index, match_kind, squared_distance);
        end else begin
          want = expected_mappings.pop_front();
          if (color_index !== want.index) begin
            error_count++;
            $display("%0t: color_index expected %0d got %0d", $time, want.index, color_index);
          end
          if (match_kind !== want.kind) begin
            error_count++;
            $display("%0t: match_kind expected %0d got %0d", $time, want.kind, match_kind);
          end
          if (squared_distance !== want.sq_dist) begin
            error_count++;
            $display("%0t: squared_distance expected %0d got %0d", $time, want.sq_dist,
                     squared_distance);
          end
        end
      end
      if (cfg_valid && cfg_ready) palette_size = cfg_data;
      if (start && !busy) begin
        map_pixel({red, green, blue}, fresh);
        expected_mappings.push_back(fresh);
      end
    end
    results_outstanding = expected_mappings.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: palette color mapper testbench
// Directed palette corner cases, then random pixel streams over several
// palette sizes; a side checker predicts every mapping and counts errors.
// ----------------------------------------------------------------------------
module tb;
  import apcm_pkg::*;

  localparam int unsigned MAX_ENTRIES    = 256;
  // the watchdog limit covers the worst scan at MAX_ENTRIES and the longest sender gap
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = MAX_ENTRIES + 40;
  localparam int          NUM_PHASES     = 6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CHAN_W-1:0]    red = '0;
  logic [CHAN_W-1:0]    green = '0;
  logic [CHAN_W-1:0]    blue = '0;
  logic                 done;
  logic [INDEX_W-1:0]   color_index;
  logic [KIND_W-1:0]    match_kind;
  logic [DIST_W-1:0]    squared_distance;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SIZE_W-1:0]    cfg_data = '0;

  int                   error_count;
  int                   results_outstanding;
  int                   quiet_cycles = 0;
  bit                   allow_gaps = 1'b1;
  logic [3*CHAN_W-1:0]  sent_colors [$];
  int                   phase_size  [NUM_PHASES];
  int                   phase_items [NUM_PHASES];

  always #5 clk = ~clk;

  adaptive_palette_color_mapper_unit #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue),
    .done(done), .color_index(color_index), .match_kind(match_kind),
    .squared_distance(squared_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  apcm_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red(red), .green(green), .blue(blue),
    .done(done), .color_index(color_index), .match_kind(match_kind),
    .squared_distance(squared_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .error_count(error_count), .results_outstanding(results_outstanding)
  );

  // Watchdog: any accepted request, result or config write resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request: drive at the falling edge, hold until taken with busy low.
  task automatic send_pixel(input logic [3*CHAN_W-1:0] color);
    red   = color[23:16];
    green = color[15:8];
    blue  = color[7:0];
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    sent_colors.push_back(color);
  endtask

  // Sender stall burst, skipped for most requests and in the closing phase.
  task automatic maybe_stall();
    if (allow_gaps && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  // Hold off until every predicted mapping has come back.
  task automatic wait_drained();
    start = 1'b0;
    while (results_outstanding != 0) @(negedge clk);
  endtask

  // Register writes only happen with the block drained.
  task automatic set_palette_size(input logic [SIZE_W-1:0] size);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = size;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 14)) - 7;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] rail();
    return $urandom_range(0, 1) ? 8'hff : 8'h00;
  endfunction

  // Mix: repeats of earlier colors (exact hits), small perturbations
  // (nearest lookups / close new entries), fully random, rail-to-rail.
  function automatic logic [3*CHAN_W-1:0] pick_color();
    int unsigned         sel;
    logic [3*CHAN_W-1:0] base;
    sel = $urandom_range(0, 99);
    if (sent_colors.size() == 0 || sel < 30) return 24'($urandom);
    if (sel >= 90) return {rail(), rail(), rail()};
    base = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
    if (sel < 60) return base;
    return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
  endfunction

  initial begin
    phase_size  = '{20, 64, 0, 200, 511, 256};
    phase_items = '{200, 200, 150, 250, 450, 250};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty palette with no room: index 0, nearest, distance 0
    set_palette_size(9'd0);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);

    // single entry: worst-case distance, then exact hit
    set_palette_size(9'd1);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h000000);

    // fill to five, per-channel extremes
    set_palette_size(9'd5);
    send_pixel(24'h020000);
    send_pixel(24'hffffff);
    send_pixel(24'h808080);
    send_pixel(24'haa55aa);
    send_pixel(24'h010000);
    send_pixel(24'h7f7f7f);
    send_pixel(24'h55aa55);
    send_pixel(24'hffffff);
    send_pixel(24'hff0000);
    send_pixel(24'h00ff00);
    send_pixel(24'h0000ff);

    // size below entries in use: everything still searched, nothing added
    set_palette_size(9'd2);
    send_pixel(24'h123456);
    send_pixel(24'h808080);
    send_pixel(24'hfe0101);

    // random phases; 511 checks saturation at MAX_ENTRIES, last has no gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_palette_size(phase_size[p][SIZE_W-1:0]);
      allow_gaps = (p != NUM_PHASES - 1);
      for (int n = 0; n < phase_items[p]; n++) begin
        maybe_stall();
        send_pixel(pick_color());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && results_outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
